// ===== rtl/core/qdpr_pkg.sv =====
// Package for the quantized dot product / requantization core.
// Holds shared widths, the lane request and result structs, and the result queue size.
// No dependencies.
package qdpr_pkg;

  localparam int WEIGHT_W = 8;
  localparam int ACT_W    = 16;
  localparam int ACC_W    = 32;
  localparam int MUL_W    = 32;
  localparam int SHIFT_W  = 6;
  localparam int ZERO_W   = 8;
  localparam int QUANT_W  = 4;
  localparam int PROD_W   = WEIGHT_W + 1 + ACT_W;

  // Result queue: must cover every request in flight through the lanes.
  localparam int RES_DEPTH = 8;
  localparam int RES_AW    = $clog2(RES_DEPTH);

  localparam logic [QUANT_W-1:0] QUANT_MAX = 4'hF;

  // Per-request control and shared operands handed to each lane.
  typedef struct packed {
    logic                       valid;
    logic                       first;
    logic                       last;
    logic [WEIGHT_W-1:0]        weight;
    logic [WEIGHT_W-1:0]        weight_zero;
    logic [ACC_W-1:0]           row_bias;
    logic signed [MUL_W-1:0]    multiplier;
    logic signed [SHIFT_W-1:0]  shift;
  } lane_req_t;

  typedef struct packed {
    logic               valid;
    logic [QUANT_W-1:0] quant;
  } lane_res_t;

endpackage

// ===== rtl/core/quantized_dot_product_requant_u4_core.sv =====
// Top level of the quantized dot product core with per-channel 4-bit requantization.
// Instantiates two qdpr_lane copies and qdpr_merge; depends on qdpr_pkg.
//
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+-------------------------------------------
// s_axis   | in  | s_axis_tvalid/tready   | tdata: weights, acts, bias, mult, shift
//          |     |                        | tuser: first, tlast: last
// m_axis   | out | m_axis_tvalid/tready   | tdata: quant_first, quant_second
// cfg      | in  | cfg_wen (no wait)      | cfg_wdata: output_zero
//
// Cycles: one request per clock while s_axis_tready is high; the per-pixel accumulator update
//   is the only loop in the lanes and closes within stage 2.
// Path: a request marked last passes the lane stages and the result queue before m_axis.
// Stalls: results wait in an 8-entry queue; s_axis_tready drops only when queued plus
//   in-flight results would fill it, so m_axis back-pressure never stalls the lanes mid-flight.
// Reset: rst clears accumulators, output_zero, pipeline valids and the queue.
module quantized_dot_product_requant_u4_core import qdpr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  // bits from 0 up: weight[7:0], weight_zero[15:8], act_first[31:16],
  // act_second[47:32], row_bias[79:48], multiplier[111:80], shift[117:112], zero pad
  input  logic [119:0]  s_axis_tdata,
  input  logic          s_axis_tuser,  // first
  input  logic          s_axis_tlast,  // last
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // bits from 0 up: quant_first[3:0], quant_second[7:4]
  output logic [7:0]    m_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_wen,
  input  logic [7:0]    cfg_wdata
);

  logic [ZERO_W-1:0] output_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_zero <= '0;
    end else if (cfg_wen) begin
      output_zero <= cfg_wdata;
    end
  end

  // Request accepted this cycle; shared operands fan out to both lanes.
  logic      taken;
  lane_req_t req;

  assign taken = s_axis_tvalid & s_axis_tready;

  always_comb begin
    req.valid       = taken;
    req.first       = s_axis_tuser;
    req.last        = s_axis_tlast;
    req.weight      = s_axis_tdata[7:0];
    req.weight_zero = s_axis_tdata[15:8];
    req.row_bias    = s_axis_tdata[79:48];
    req.multiplier  = s_axis_tdata[111:80];
    req.shift       = s_axis_tdata[117:112];
  end

  lane_res_t res_first, res_second;

  qdpr_lane u_lane_first (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .act         (s_axis_tdata[31:16]),
    .output_zero (output_zero),
    .res         (res_first)
  );

  qdpr_lane u_lane_second (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .act         (s_axis_tdata[47:32]),
    .output_zero (output_zero),
    .res         (res_second)
  );

  // Credits counted on every taken request that will produce a result.
  qdpr_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .res_first  (res_first),
    .res_second (res_second),
    .last_taken (taken & s_axis_tlast),
    .room       (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule

// ===== rtl/core/qdpr_lane.sv =====
// One pixel lane: weight/activation MAC, accumulator, and requantization pipeline.
// Depends on qdpr_pkg.
module qdpr_lane import qdpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  lane_req_t                req,
  input  logic signed [ACT_W-1:0]  act,
  input  logic [ZERO_W-1:0]        output_zero,
  output lane_res_t                res
);

  // stage 1: product
  logic                      s1_valid, s1_first, s1_last;
  logic signed [PROD_W-1:0]  s1_prod;
  logic [ACC_W-1:0]          s1_bias;
  logic signed [MUL_W-1:0]   s1_mul;
  logic signed [SHIFT_W-1:0] s1_shift;

  logic signed [WEIGHT_W:0]  diff;
  logic signed [PROD_W-1:0]  prod_c;

  assign diff   = $signed({1'b0, req.weight}) - $signed({1'b0, req.weight_zero});
  assign prod_c = diff * act;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
    end
    s1_first <= req.first;
    s1_last  <= req.last;
    s1_prod  <= prod_c;
    s1_bias  <= req.row_bias;
    s1_mul   <= req.multiplier;
    s1_shift <= req.shift;
  end

  // stage 2: accumulate (wraps mod 2^32)
  logic [ACC_W-1:0]          acc, acc_next;
  logic                      s2_valid;
  logic [ACC_W-1:0]          s2_sum;
  logic signed [MUL_W-1:0]   s2_mul;
  logic signed [SHIFT_W-1:0] s2_shift;

  assign acc_next = (s1_first ? s1_bias : acc)
                  + {{(ACC_W-PROD_W){s1_prod[PROD_W-1]}}, s1_prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_valid) begin
        acc <= acc_next;
      end
      s2_valid <= s1_valid & s1_last;
    end
    s2_sum   <= acc_next;
    s2_mul   <= s1_mul;
    s2_shift <= s1_shift;
  end

  // stage 3: left shift for negative shift; shift of -32 clears the sum
  logic [SHIFT_W:0]          lsh;
  logic                      s3_valid;
  logic [ACC_W-1:0]          s3_x;
  logic signed [MUL_W-1:0]   s3_mul;
  logic [SHIFT_W-2:0]        s3_rsh;

  assign lsh = (SHIFT_W+1)'(0) - {s2_shift[SHIFT_W-1], s2_shift};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_x   <= s2_shift[SHIFT_W-1] ? (s2_sum << lsh) : s2_sum;
    s3_mul <= s2_mul;
    s3_rsh <= s2_shift[SHIFT_W-1] ? '0 : s2_shift[SHIFT_W-2:0];
  end

  // stage 4: 32x32 signed multiply
  logic                          s4_valid;
  logic signed [ACC_W+MUL_W-1:0] s4_prod;
  logic [SHIFT_W-2:0]            s4_rsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_prod <= $signed(s3_x) * s3_mul;
    s4_rsh  <= s3_rsh;
  end

  // stage 5: keep high word, arithmetic right shift, add zero point, clamp
  logic signed [MUL_W-1:0] hi, hi_sh;
  logic [MUL_W:0]          biased;
  logic [QUANT_W-1:0]      quant_c;

  assign hi     = s4_prod[ACC_W+MUL_W-1:ACC_W];
  assign hi_sh  = hi >>> s4_rsh;
  assign biased = {hi_sh[MUL_W-1], hi_sh} + {{(MUL_W+1-ZERO_W){1'b0}}, output_zero};

  always_comb begin
    if (biased[MUL_W]) begin
      quant_c = '0;
    end else if (|biased[MUL_W-1:QUANT_W]) begin
      quant_c = QUANT_MAX;
    end else begin
      quant_c = biased[QUANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= s4_valid;
    end
    res.quant <= quant_c;
  end

endmodule

// ===== rtl/core/qdpr_merge.sv =====
// Merge stage: joins the two lane results into one output request and queues it.
// Credit count of queued plus in-flight results gates input acceptance. Depends on qdpr_pkg.
module qdpr_merge import qdpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  lane_res_t              res_first,
  input  lane_res_t              res_second,
  input  logic                   last_taken,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2*QUANT_W-1:0]   out_data
);

  logic [2*QUANT_W-1:0] mem [RES_DEPTH];
  logic [RES_AW-1:0]    wr_ptr, rd_ptr;
  logic [RES_AW:0]      count, credits;
  logic                 push, pop;

  assign push      = res_first.valid & res_second.valid;
  assign out_valid = count != '0;
  assign pop       = out_valid & out_ready;
  assign out_data  = mem[rd_ptr];
  assign room      = credits < (RES_AW+1)'(RES_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {res_second.quant, res_first.quant};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      credits <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count   <= count + {{RES_AW{1'b0}}, push} - {{RES_AW{1'b0}}, pop};
      credits <= credits + {{RES_AW{1'b0}}, last_taken} - {{RES_AW{1'b0}}, pop};
    end
  end

endmodule
